@@ rtl/igws_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// igws_pkg
// Shared types, constants and helpers of the idle governor / workload split.
// ----------------------------------------------------------------------------
package igws_pkg;

    localparam int MAX_UNITS  = 16;
    localparam int UNIT_CW    = $clog2(MAX_UNITS + 1);   // unit count width
    localparam int UNIT_IW    = $clog2(MAX_UNITS);       // unit id width
    localparam int MARK_W     = 7;
    localparam int DELAY_W    = 48;
    localparam int CNT_W      = 32;
    localparam int TS_W       = 64;
    localparam int PROD_W     = CNT_W + MARK_W;          // scaled idle compare width
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam int DIV_CW     = $clog2(UNIT_CW + 1);

    localparam logic [MARK_W-1:0]  IDLE_SCALE  = MARK_W'(100);
    localparam logic [MARK_W-1:0]  RST_HIGH    = MARK_W'(95);
    localparam logic [MARK_W-1:0]  RST_LOW     = MARK_W'(85);
    localparam logic [DELAY_W-1:0] RST_DELAY   = DELAY_W'(64'd3000000000);
    localparam logic [UNIT_CW-1:0] RST_UNITS   = UNIT_CW'(MAX_UNITS);

    // register map, one 64-bit register every 8 bytes
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;
    typedef enum logic [1:0] {
        REG_HIGH  = 2'd0,
        REG_LOW   = 2'd1,
        REG_DELAY = 2'd2,
        REG_UNITS = 2'd3
    } t_reg;

    typedef struct packed {
        logic [MARK_W-1:0]  high_mark;
        logic [MARK_W-1:0]  low_mark;
        logic [DELAY_W-1:0] delay;
        logic [UNIT_CW-1:0] num_units;
    } t_cfg;

    // interval class decided by the front end
    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_HIGH = 2'd1,
        CLS_LOW  = 2'd2
    } t_cls;

    typedef struct packed {
        t_cls            cls;
        logic [TS_W-1:0] now;
    } t_job;

    typedef struct packed {
        logic [UNIT_IW-1:0] unit_id;
        logic [UNIT_CW-1:0] workload;
        logic [UNIT_CW-1:0] active_count;
        logic               slow_spin;
        logic               last;
    } t_result;

    typedef enum logic [1:0] {
        BST_IDLE = 2'd0,
        BST_DIV  = 2'd1,
        BST_EMIT = 2'd2
    } t_bst;

    // unit count as used: 0 acts as 1, above MAX_UNITS acts as MAX_UNITS
    function automatic logic [UNIT_CW-1:0] eff_units(input logic [UNIT_CW-1:0] n);
        logic [UNIT_CW-1:0] r;
        r = n;
        if (r == '0) begin
            r = UNIT_CW'(1);
        end
        if (r > UNIT_CW'(MAX_UNITS)) begin
            r = UNIT_CW'(MAX_UNITS);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/idle_governor_workload_split.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// idle_governor_workload_split
// Idle-driven active unit governor with per-unit work queue split.
// ----------------------------------------------------------------------------
// The back end paces intervals: a pop/update step, a 5-step serial divider,
//   then one result word per unit in use (1..16), one per cycle while the
//   output is not stalled; the front end and 2-entry queue run ahead.
// Reset (synchronous, active low): config to 95/85/3e9/16, active count 16,
//   slow-spin off, hold-off deadline 0, queue and pipeline empty.
// ----------------------------------------------------------------------------
module idle_governor_workload_split (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // config port, registers every 8 bytes
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [igws_pkg::PADDR_W-1:0]      paddr,
    input  wire  [igws_pkg::PDATA_W-1:0]      pwdata,
    output logic [igws_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    // interval words in
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire  [127:0]                      s_axis_tdata,  // wake_count, nowork_count, now
    // per-unit result words out
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [15:0]                       m_axis_tdata,  // unit_id, workload,
                                                             // active_count, slow_spin, pad
    output logic                              m_axis_tlast
);

    localparam int CW = igws_pkg::CNT_W;

    igws_pkg::t_cfg    r_cfg;
    igws_pkg::t_job    front_job;
    igws_pkg::t_job    queue_job;
    igws_pkg::t_result result;
    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    logic              cfg_wr;
    igws_pkg::t_reg    reg_sel;

    // --- config registers ---
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = igws_pkg::t_reg'(paddr[4:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_mark <= igws_pkg::RST_HIGH;
            r_cfg.low_mark  <= igws_pkg::RST_LOW;
            r_cfg.delay     <= igws_pkg::RST_DELAY;
            r_cfg.num_units <= igws_pkg::RST_UNITS;
        end else if (cfg_wr) begin
            case (reg_sel)
                igws_pkg::REG_HIGH:  r_cfg.high_mark <= pwdata[igws_pkg::MARK_W-1:0];
                igws_pkg::REG_LOW:   r_cfg.low_mark  <= pwdata[igws_pkg::MARK_W-1:0];
                igws_pkg::REG_DELAY: r_cfg.delay     <= pwdata[igws_pkg::DELAY_W-1:0];
                igws_pkg::REG_UNITS: r_cfg.num_units <= pwdata[igws_pkg::UNIT_CW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            igws_pkg::REG_HIGH:  prdata = igws_pkg::PDATA_W'(r_cfg.high_mark);
            igws_pkg::REG_LOW:   prdata = igws_pkg::PDATA_W'(r_cfg.low_mark);
            igws_pkg::REG_DELAY: prdata = igws_pkg::PDATA_W'(r_cfg.delay);
            igws_pkg::REG_UNITS: prdata = igws_pkg::PDATA_W'(r_cfg.num_units);
            default:             prdata = '0;
        endcase
    end

    // --- front end: capture, scale, classify ---
    igws_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_wake   (s_axis_tdata[CW-1:0]),
        .i_nowork (s_axis_tdata[2*CW-1:CW]),
        .i_now    (s_axis_tdata[127:2*CW]),
        .o_push   (push),
        .o_job    (front_job),
        .i_full   (full)
    );

    // --- decoupling queue ---
    igws_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_empty (empty)
    );

    // --- back end: governor state, divide, emit ---
    igws_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (empty),
        .i_job    (queue_job),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    // result word packing, unit_id in the low bits
    assign m_axis_tdata = {1'b0, result.slow_spin, result.active_count,
                           result.workload, result.unit_id};
    assign m_axis_tlast = result.last;

endmodule
`default_nettype wire

@@ rtl/igws_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// igws_front
// Takes interval words, scales idle and mark products, classifies the interval.
// ----------------------------------------------------------------------------
module igws_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  igws_pkg::t_cfg               i_cfg,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire  [igws_pkg::CNT_W-1:0]   i_wake,
    input  wire  [igws_pkg::CNT_W-1:0]   i_nowork,
    input  wire  [igws_pkg::TS_W-1:0]    i_now,
    output logic                         o_push,
    output igws_pkg::t_job               o_job,
    input  wire                          i_full
);

    logic                          r_s1_valid;
    logic [igws_pkg::CNT_W-1:0]    r_s1_wake;
    logic [igws_pkg::CNT_W-1:0]    r_s1_nowork;
    logic [igws_pkg::TS_W-1:0]     r_s1_now;

    logic                          r_s2_valid;
    logic [igws_pkg::PROD_W-1:0]   r_s2_idle;
    logic [igws_pkg::PROD_W-1:0]   r_s2_high;
    logic [igws_pkg::PROD_W-1:0]   r_s2_low;
    logic                          r_s2_zero;
    logic [igws_pkg::TS_W-1:0]     r_s2_now;

    logic s2_adv;
    logic accept;

    assign o_push  = r_s2_valid && !i_full;
    assign s2_adv  = !r_s2_valid || o_push;
    assign o_ready = !r_s1_valid || s2_adv;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s2_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_adv) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_wake   <= i_wake;
            r_s1_nowork <= i_nowork;
            r_s1_now    <= i_now;
        end
        if (s2_adv && r_s1_valid) begin
            // cross-multiplied compare operands: 100*nowork vs mark*wake
            r_s2_idle <= igws_pkg::PROD_W'(r_s1_nowork) *
                         igws_pkg::PROD_W'(igws_pkg::IDLE_SCALE);
            r_s2_high <= igws_pkg::PROD_W'(r_s1_wake) *
                         igws_pkg::PROD_W'(i_cfg.high_mark);
            r_s2_low  <= igws_pkg::PROD_W'(r_s1_wake) *
                         igws_pkg::PROD_W'(i_cfg.low_mark);
            r_s2_zero <= (r_s1_wake == '0);
            r_s2_now  <= r_s1_now;
        end
    end

    always_comb begin
        o_job.now = r_s2_now;
        if (r_s2_zero) begin
            o_job.cls = igws_pkg::CLS_NONE;
        end else if (r_s2_idle > r_s2_high) begin
            o_job.cls = igws_pkg::CLS_HIGH;
        end else if (r_s2_idle < r_s2_low) begin
            o_job.cls = igws_pkg::CLS_LOW;
        end else begin
            o_job.cls = igws_pkg::CLS_NONE;
        end
    end

endmodule
`default_nettype wire

@@ rtl/igws_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// igws_fifo
// Short job queue between the classifier and the governor back end.
// ----------------------------------------------------------------------------
module igws_fifo (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  igws_pkg::t_job  i_job,
    output logic            o_full,
    input  wire             i_pop,
    output igws_pkg::t_job  o_job,
    output logic            o_empty
);

    igws_pkg::t_job                     r_mem [igws_pkg::FIFO_DEPTH];
    logic [igws_pkg::FIFO_AW-1:0]       r_wptr;
    logic [igws_pkg::FIFO_AW-1:0]       r_rptr;
    logic [igws_pkg::FIFO_CW-1:0]       r_count;

    assign o_full  = (r_count == igws_pkg::FIFO_CW'(igws_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule
`default_nettype wire

@@ rtl/igws_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// igws_back
// Governor state update, serial split divider and per-unit result emitter.
// ----------------------------------------------------------------------------
module igws_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  igws_pkg::t_cfg       i_cfg,
    input  wire                  i_empty,
    input  igws_pkg::t_job       i_job,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire                  i_ready,
    output igws_pkg::t_result    o_result
);

    localparam int UCW = igws_pkg::UNIT_CW;

    igws_pkg::t_bst              r_state, n_state;
    logic [UCW-1:0]              r_active, n_active;
    logic                        r_slow, n_slow;
    logic [igws_pkg::TS_W-1:0]   r_deadline, n_deadline;
    logic [UCW-1:0]              r_n, n_n;
    logic [UCW-1:0]              r_rem, n_rem;
    logic [UCW-1:0]              r_dq, n_dq;
    logic [igws_pkg::DIV_CW-1:0] r_cnt, n_cnt;
    logic [UCW-1:0]              r_unit, n_unit;
    logic                        r_ovalid, n_ovalid;
    igws_pkg::t_result           r_out, n_out;

    logic [UCW-1:0]              eff_n;
    logic [UCW-1:0]              act_c;
    logic [UCW:0]                act_dbl;
    logic [igws_pkg::TS_W-1:0]   rearm;
    logic [UCW:0]                partial;
    logic [UCW-1:0]              first_big;
    logic                        out_free;

    assign o_valid  = r_ovalid;
    assign o_result = r_out;
    assign out_free = !r_ovalid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= igws_pkg::BST_IDLE;
            r_active   <= igws_pkg::RST_UNITS;
            r_slow     <= 1'b0;
            r_deadline <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_active   <= n_active;
            r_slow     <= n_slow;
            r_deadline <= n_deadline;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_rem  <= n_rem;
        r_dq   <= n_dq;
        r_cnt  <= n_cnt;
        r_unit <= n_unit;
        r_out  <= n_out;
    end

    always_comb begin
        eff_n = igws_pkg::eff_units(i_cfg.num_units);
        act_c = r_active;
        if (act_c == '0) begin
            act_c = UCW'(1);
        end
        if (act_c > eff_n) begin
            act_c = eff_n;
        end
        act_dbl   = {act_c, 1'b0};
        rearm     = i_job.now + igws_pkg::TS_W'(i_cfg.delay);
        partial   = {r_rem, r_dq[UCW-1]};
        first_big = r_active - r_rem;

        n_state    = r_state;
        n_active   = r_active;
        n_slow     = r_slow;
        n_deadline = r_deadline;
        n_n        = r_n;
        n_rem      = r_rem;
        n_dq       = r_dq;
        n_cnt      = r_cnt;
        n_unit     = r_unit;
        n_ovalid   = r_ovalid && !i_ready;
        n_out      = r_out;
        o_pop      = 1'b0;

        case (r_state)
            igws_pkg::BST_IDLE: begin
                if (!i_empty) begin
                    o_pop    = 1'b1;
                    n_n      = eff_n;
                    n_active = act_c;
                    case (i_job.cls)
                        igws_pkg::CLS_HIGH: begin
                            if (i_job.now > r_deadline) begin
                                if (act_c == UCW'(1)) begin
                                    n_slow = 1'b1;
                                end else begin
                                    n_active = act_c - 1'b1;
                                end
                                n_deadline = rearm;
                            end
                        end
                        igws_pkg::CLS_LOW: begin
                            if (r_slow) begin
                                n_slow = 1'b0;
                            end else if (act_c < eff_n) begin
                                n_active = (act_dbl > {1'b0, eff_n}) ? eff_n
                                                                     : act_dbl[UCW-1:0];
                            end
                            n_deadline = rearm;
                        end
                        default: begin
                        end
                    endcase
                    // restoring divide: eff_n / active
                    n_rem   = '0;
                    n_dq    = eff_n;
                    n_cnt   = '0;
                    n_state = igws_pkg::BST_DIV;
                end
            end
            igws_pkg::BST_DIV: begin
                if (partial >= {1'b0, r_active}) begin
                    n_rem = UCW'(partial - {1'b0, r_active});
                    n_dq  = {r_dq[UCW-2:0], 1'b1};
                end else begin
                    n_rem = partial[UCW-1:0];
                    n_dq  = {r_dq[UCW-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == igws_pkg::DIV_CW'(UCW - 1)) begin
                    n_unit  = '0;
                    n_state = igws_pkg::BST_EMIT;
                end
            end
            igws_pkg::BST_EMIT: begin
                if (out_free) begin
                    n_ovalid           = 1'b1;
                    n_out.unit_id      = r_unit[igws_pkg::UNIT_IW-1:0];
                    n_out.active_count = r_active;
                    n_out.slow_spin    = r_slow;
                    n_out.last         = (r_unit + 1'b1 == r_n);
                    if (r_unit >= r_active) begin
                        n_out.workload = '0;
                    end else if (r_unit >= first_big) begin
                        n_out.workload = r_dq + 1'b1;
                    end else begin
                        n_out.workload = r_dq;
                    end
                    n_unit = r_unit + 1'b1;
                    if (r_unit + 1'b1 == r_n) begin
                        n_state = igws_pkg::BST_IDLE;
                    end
                end
            end
            default: begin
                n_state = igws_pkg::BST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for idle_governor_workload_split. Interval words go in
// on the slave stream, per-unit workload words come back on the master stream
// and are checked field by field against an in-bench governor model. Config
// is written over APB between phases while the block is drained. Directed
// corner cases run first, then randomized phases with random valid gaps and
// ready stalls.
// ----------------------------------------------------------------------------
module tb;
    import igws_pkg::*;

    localparam int DRAIN_CYCLES = 16;    // settle time after the last expected word
    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all

    // ------------------------------------------------------------------
    // clock, reset, DUT ports
    // ------------------------------------------------------------------
    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;

    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [PADDR_W-1:0]   paddr   = '0;
    logic [PDATA_W-1:0]   pwdata  = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [127:0]         s_axis_tdata  = '0;   // wake_count, nowork_count, now

    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;         // unit_id, workload, active_count,
                                                // slow_spin, pad
    logic                 m_axis_tlast;

    always #10 i_clk = ~i_clk;

    idle_governor_workload_split uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // governor model: config copy, state, expected workload words
    // ------------------------------------------------------------------
    logic [MARK_W-1:0]  cfg_high  = RST_HIGH;
    logic [MARK_W-1:0]  cfg_low   = RST_LOW;
    logic [DELAY_W-1:0] cfg_delay = RST_DELAY;
    logic [UNIT_CW-1:0] cfg_units = RST_UNITS;

    logic [UNIT_CW-1:0] gov_active   = RST_UNITS;
    logic               gov_slow     = 1'b0;
    logic [TS_W-1:0]    gov_deadline = '0;

    t_result            unit_loads_q[$];   // expected words, oldest first

    int                 n_errors   = 0;
    int                 idle_count = 0;
    bit                 feed_gaps    = 1'b1;   // sender inserts valid gaps
    bit                 drain_stalls = 1'b1;   // receiver drops ready
    logic [TS_W-1:0]    tick = '0;             // running timestamp for stimulus

    // Advance the governor by one interval and queue one word per unit.
    task automatic governor_step(input logic [CNT_W-1:0] wake,
                                 input logic [CNT_W-1:0] nowork,
                                 input logic [TS_W-1:0]  now);
        int          n;
        int          act;
        int          base;
        int          first_big;
        logic [63:0] scaled;
        t_result     w;

        // unit count in use: 0 acts as 1, above MAX_UNITS saturates
        n = cfg_units;
        if (n < 1) n = 1;
        if (n > MAX_UNITS) n = MAX_UNITS;
        // stored active count is clamped before use and kept clamped
        act = gov_active;
        if (act < 1) act = 1;
        if (act > n) act = n;

        // zero wake count: marks not tested, state untouched
        if (wake != '0) begin
            scaled = 64'(nowork) * 64'd100;
            if (scaled > 64'(cfg_high) * 64'(wake)) begin
                // reductions only once the hold-off has passed (strict compare)
                if (now > gov_deadline) begin
                    if (act == 1) gov_slow = 1'b1;
                    else act = act - 1;
                    gov_deadline = now + 64'(cfg_delay);   // wraps mod 2^64
                end
            end else if (scaled < 64'(cfg_low) * 64'(wake)) begin
                if (gov_slow) begin
                    gov_slow = 1'b0;
                end else if (act < n) begin
                    act = act * 2;
                    if (act > n) act = n;
                end
                gov_deadline = now + 64'(cfg_delay);
            end
        end
        gov_active = UNIT_CW'(act);

        // floor split; the top (n mod act) active units take one extra queue
        base      = n / act;
        first_big = act - (n % act);
        for (int u = 0; u < n; u++) begin
            w.unit_id      = UNIT_IW'(u);
            w.workload     = (u >= act) ? '0 :
                             UNIT_CW'((u >= first_big) ? base + 1 : base);
            w.active_count = UNIT_CW'(act);
            w.slow_spin    = gov_slow;
            w.last         = (u == n - 1);
            unit_loads_q.push_back(w);
        end
    endtask

    // ------------------------------------------------------------------
    // mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("%0t: mismatch on %s, expected %0d, got %0d", $time, what, want, got);
        n_errors++;
    endtask

    // ------------------------------------------------------------------
    // stimulus side
    // ------------------------------------------------------------------
    // Send one interval word; predicts at the accepting edge. tvalid stays
    // high on return so back-to-back words need no extra assignment.
    task automatic send_interval(input logic [CNT_W-1:0] wake,
                                 input logic [CNT_W-1:0] nowork,
                                 input logic [TS_W-1:0]  now);
        int gap;
        gap = feed_gaps ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {now, nowork, wake};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        governor_step(wake, nowork, now);
    endtask

    // Stop sending, wait for every expected word, then let the pipe settle.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (unit_loads_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write, back-to-back capable: leaves psel high, caller closes the bus.
    task automatic write_reg(input t_reg idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            REG_HIGH:  cfg_high  = value[MARK_W-1:0];
            REG_LOW:   cfg_low   = value[MARK_W-1:0];
            REG_DELAY: cfg_delay = value[DELAY_W-1:0];
            REG_UNITS: cfg_units = value[UNIT_CW-1:0];
            default: ;
        endcase
    endtask

    // Only call with the block drained.
    task automatic set_config(input logic [MARK_W-1:0]  high_mark,
                              input logic [MARK_W-1:0]  low_mark,
                              input logic [DELAY_W-1:0] delay,
                              input logic [UNIT_CW-1:0] units);
        write_reg(REG_HIGH,  64'(high_mark));
        write_reg(REG_LOW,   64'(low_mark));
        write_reg(REG_DELAY, 64'(delay));
        write_reg(REG_UNITS, 64'(units));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // receive side: random ready stalls before each word, with
    // occasional stretches of no stalls at all
    // ------------------------------------------------------------------
    initial begin : ready_driver
        int gap;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 47) == 0) drain_stalls = !drain_stalls;
            gap = drain_stalls ? $urandom_range(0, 3) : 0;
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid === 1'b1 && m_axis_tready));
        end
    end

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    t_result due;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (unit_loads_q.size() == 0) begin
                report_mismatch("unexpected word, unit_id", 0, m_axis_tdata[UNIT_IW-1:0]);
            end else begin
                due = unit_loads_q.pop_front();
                if (m_axis_tdata[UNIT_IW-1:0] !== due.unit_id)
                    report_mismatch("unit_id", due.unit_id, m_axis_tdata[UNIT_IW-1:0]);
                if (m_axis_tdata[UNIT_IW +: UNIT_CW] !== due.workload)
                    report_mismatch("workload", due.workload,
                                    m_axis_tdata[UNIT_IW +: UNIT_CW]);
                if (m_axis_tdata[UNIT_IW+UNIT_CW +: UNIT_CW] !== due.active_count)
                    report_mismatch("active_count", due.active_count,
                                    m_axis_tdata[UNIT_IW+UNIT_CW +: UNIT_CW]);
                if (m_axis_tdata[UNIT_IW+2*UNIT_CW] !== due.slow_spin)
                    report_mismatch("slow_spin", due.slow_spin,
                                    m_axis_tdata[UNIT_IW+2*UNIT_CW]);
                if (m_axis_tlast !== due.last)
                    report_mismatch("tlast", due.last, m_axis_tlast);
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: any handshake on either stream or the APB port resets it
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready === 1'b1) ||
            (m_axis_tvalid === 1'b1 && m_axis_tready) || (psel && penable)) begin
            idle_count <= 0;
        end else if (idle_count >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // Reset config: zero wake, hold-off expiry, marks hit exactly, doubling.
    task automatic test_reset_config();
        send_interval('0, '1, 64'd0);                      // zero wake, no change
        send_interval(32'd100, 32'd100, 64'd1);            // 100% idle: 16 -> 15
        send_interval(32'd100, 32'd100, 64'd2);            // still held off
        send_interval(32'd100, 32'd100, 64'd3000000002);   // expired: 15 -> 14
        send_interval(32'd1, '1, 64'd3000000003);          // nowork > wake, held
        send_interval(32'd100, 32'd95, 64'd9000000000);    // exactly high mark
        send_interval(32'd100, 32'd85, 64'd9000000001);    // exactly low mark
        send_interval(32'd100, 32'd0, 64'd9000000002);     // busy: double, saturate
        send_interval('1, '0, 64'd9000000003);             // busy at full count
        tick = 64'd9000000004;
    endtask

    // One unit: clamp to 1, busy at n, and a reduction there turns into slow-spin.
    task automatic test_single_unit();
        wait_drained();
        set_config(7'd95, 7'd85, '0, 5'd1);
        send_interval(32'd100, 32'd100, tick + 1);         // clamp to 1, still held off
        send_interval(32'd100, 32'd0, tick + 2);           // busy, no spin to clear
        send_interval(32'd100, 32'd0, tick + 3);           // already at n
        wait_drained();
        set_config(7'd95, 7'd85, '0, 5'd0);                // 0 acts as 1
        send_interval(32'd100, 32'd100, tick + 4);
        tick = tick + 5;
    endtask

    // Unit count above MAX_UNITS, spin cleared and doubling to 8, then uneven splits.
    task automatic test_unit_clamp();
        wait_drained();
        set_config(7'd95, 7'd85, '0, 5'd31);
        repeat (4) begin
            tick = tick + 1;
            send_interval(32'd10, 32'd0, tick);            // clear spin, then 1 -> 2 -> 4 -> 8
        end
        wait_drained();
        set_config(7'd95, 7'd85, '0, 5'd5);
        repeat (3) begin
            tick = tick + 1;
            send_interval(32'd10, 32'd10, tick);           // 5 -> 4 -> 3 -> 2
        end
    endtask

    // Marks at 0 and at 127.
    task automatic test_mark_extremes();
        wait_drained();
        set_config(7'd0, 7'd0, '0, 5'd16);
        send_interval(32'd10, 32'd1, tick + 1);            // any idle is high
        send_interval(32'd10, 32'd0, tick + 2);            // neither
        wait_drained();
        set_config(7'd127, 7'd127, '0, 5'd16);
        send_interval(32'd10, 32'd10, tick + 3);           // 100% is below low
        send_interval(32'd1, '1, tick + 4);                // far above 100%
        tick = tick + 5;
    endtask

    // Largest hold-off, deadline wrapping past the top of the timestamp.
    task automatic test_deadline_wrap();
        wait_drained();
        set_config(7'd95, 7'd85, '1, 5'd16);
        send_interval(32'd100, 32'd100, 64'hFFFF_FFFF_FFFF_FFFE);
        send_interval(32'd100, 32'd100, '1);
        send_interval(32'd100, 32'd100, '0);
        tick = '0;
    endtask

    // Random phases, each with its own config and mostly well-formed load
    // patterns aimed above or below the marks, or spread over 0..127%.
    task automatic test_random_phases();
        logic [MARK_W-1:0]  hi;
        logic [MARK_W-1:0]  lo;
        logic [DELAY_W-1:0] dly;
        logic [UNIT_CW-1:0] units;
        logic [CNT_W-1:0]   wake;
        logic [CNT_W-1:0]   nowork;
        logic [63:0]        prod;
        int                 pct;

        repeat (6) begin
            wait_drained();
            hi = ($urandom_range(0, 3) == 0) ? MARK_W'($urandom_range(0, 127))
                                             : MARK_W'($urandom_range(60, 99));
            lo = ($urandom_range(0, 3) == 0) ? MARK_W'($urandom_range(0, 127))
                                             : MARK_W'($urandom_range(20, hi));
            case ($urandom_range(0, 3))
                0:       dly = '0;
                1:       dly = DELAY_W'($urandom_range(1, 40));
                2:       dly = DELAY_W'(64'd3000000000);
                default: dly = {16'($urandom), 32'($urandom)};
            endcase
            units = ($urandom_range(0, 3) == 0) ? UNIT_CW'($urandom_range(0, 31))
                                                : UNIT_CW'($urandom_range(1, 16));
            set_config(hi, lo, dly, units);
            feed_gaps = ($urandom_range(0, 3) != 0);

            repeat (24) begin
                // timestamp: mostly forward, around the hold-off, sometimes a jump
                case ($urandom_range(0, 7))
                    0:       tick = {$urandom, $urandom};
                    1:       ;
                    2, 3:    tick = tick + 64'(cfg_delay) + 64'($urandom_range(1, 3));
                    default: tick = tick + 64'($urandom_range(0, 3)) +
                                    (64'(cfg_delay) >> $urandom_range(1, 4));
                endcase
                case ($urandom_range(0, 9))
                    0: begin                               // empty interval
                        wake   = '0;
                        nowork = $urandom;
                    end
                    1: begin                               // noise
                        wake   = $urandom;
                        nowork = $urandom;
                    end
                    default: begin
                        wake = $urandom >> $urandom_range(0, 31);
                        if (wake == '0) wake = 32'd1;
                        case ($urandom_range(0, 19))
                            0, 1, 2, 3, 4, 5, 6, 7, 8:
                                pct = int'(cfg_high) + $urandom_range(1, 10);
                            9, 10, 11, 12, 13, 14, 15:
                                pct = (cfg_low == '0) ? 0 : $urandom_range(0, cfg_low - 1);
                            default:
                                pct = $urandom_range(0, 127);
                        endcase
                        prod   = 64'(wake) * 64'(pct) / 64'd100;
                        nowork = (prod > 64'hFFFF_FFFF) ? '1 : prod[CNT_W-1:0];
                    end
                endcase
                send_interval(wake, nowork, tick);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_config();
        test_single_unit();
        test_unit_clamp();
        test_mark_extremes();
        test_deadline_wrap();
        test_random_phases();
        wait_drained();
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/igws_pkg.sv
rtl/igws_front.sv
rtl/igws_fifo.sv
rtl/igws_back.sv
rtl/idle_governor_workload_split.sv
sim/tb.sv
